// ===== sv/rls_pkg.sv =====
// ---------------------------------------------------------------------------
// rls_pkg: shared definitions for the RGB Laplacian sharpen unit
// Sizes, register indexes, action codes and the queue entry type.
// ---------------------------------------------------------------------------
package rls_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int EW            = COL_W + 1;
    localparam int WIDTH_FIELD_W = 11;
    localparam int HEIGHT_W      = 16;
    localparam int STRENGTH_W    = 12;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int LAP_W         = 11;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_STRENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic signed [STRENGTH_W-1:0] STRENGTH_RESET = 12'sd256;
    localparam logic [WIDTH_FIELD_W-1:0]     WIDTH_RESET    = 11'd640;
    localparam logic [HEIGHT_W-1:0]          HEIGHT_RESET   = 16'd480;

    typedef struct packed {
        logic             write_en;
        logic             emit;
        logic             drain;
        logic             cbank;
        logic             north_self;
        logic             east_self;
        logic             first;
        logic             eor;
        logic             eof;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } entry_t;

endpackage

// ===== sv/rgb_laplacian_sharpen_unit.sv =====
// ---------------------------------------------------------------------------
// rgb_laplacian_sharpen_unit: streaming 3x3 cross Laplacian sharpen
// Front classifies pixels and drain ticks, a work queue decouples it from
// the back, which holds two line stores and the arithmetic pipeline.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    action, red, green, blue
//   output    out_valid / out_stall  out_red, out_green, out_blue,
//                                    end_of_row, end_of_frame
//   config    cfg_write              cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a result passes
// through the queue, line store read, Laplacian and multiply/clamp registers.
// Rate is set by one line store read and one write per bank per cycle.
// Reset clears counters and pipeline valids; line stores are not cleared.
// out_stall with a valid output freezes the back pipeline; the four-entry
// queue keeps taking input until full, then raises in_stall.
// ---------------------------------------------------------------------------
module rgb_laplacian_sharpen_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [rls_pkg::CH_W-1:0]         red,
    input  logic [rls_pkg::CH_W-1:0]         green,
    input  logic [rls_pkg::CH_W-1:0]         blue,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rls_pkg::CH_W-1:0]         out_red,
    output logic [rls_pkg::CH_W-1:0]         out_green,
    output logic [rls_pkg::CH_W-1:0]         out_blue,
    output logic                             end_of_row,
    output logic                             end_of_frame
);

    logic            push;
    rls_pkg::entry_t push_entry;
    logic            q_full;
    logic            pop;
    logic            q_valid;
    rls_pkg::entry_t q_entry;

    rls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    rls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    rls_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

endmodule

// ===== sv/rls_front.sv =====
// ---------------------------------------------------------------------------
// rls_front: input side of the sharpen unit
// Holds the frame geometry and the raster counters, classifies each
// transaction and pushes one work entry per pixel or drain tick that counts.
// ---------------------------------------------------------------------------
module rls_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [rls_pkg::CH_W-1:0]         red,
    input  logic [rls_pkg::CH_W-1:0]         green,
    input  logic [rls_pkg::CH_W-1:0]         blue,
    input  logic                             q_full,
    output logic                             push,
    output rls_pkg::entry_t                  push_entry
);

    logic [rls_pkg::WIDTH_FIELD_W-1:0] image_width_reg;
    logic [rls_pkg::HEIGHT_W-1:0]      image_height_reg;
    logic [rls_pkg::COL_W-1:0]         in_column_reg, in_column_next;
    logic [rls_pkg::HEIGHT_W-1:0]      in_row_reg, in_row_next;
    logic [rls_pkg::COL_W-1:0]         drain_column_reg, drain_column_next;

    logic [rls_pkg::EW-1:0]            eff_w;
    logic [rls_pkg::HEIGHT_W-1:0]      eff_h;
    logic                              accept;
    logic                              frame_done;
    logic [rls_pkg::COL_W-1:0]         col_sel;
    logic                              last;
    logic                              pixel_take;
    logic                              drain_take;
    logic                              geom_write;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_w = rls_pkg::EW'(1);
        end
        else if (32'(image_width_reg) > rls_pkg::MAX_WIDTH)
        begin
            eff_w = rls_pkg::EW'(rls_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = rls_pkg::EW'(image_width_reg);
        end
    end

    assign eff_h      = (image_height_reg == '0) ? rls_pkg::HEIGHT_W'(1) : image_height_reg;
    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign frame_done = (in_row_reg >= eff_h);
    assign col_sel    = (action == rls_pkg::ACT_DRAIN) ? drain_column_reg : in_column_reg;
    assign last       = ((rls_pkg::EW'(col_sel) + rls_pkg::EW'(1)) == eff_w);
    assign pixel_take = accept && (action == rls_pkg::ACT_PIXEL) && !frame_done;
    assign drain_take = accept && (action == rls_pkg::ACT_DRAIN) && frame_done;
    assign push       = pixel_take || drain_take;
    assign geom_write = cfg_write
                        && ((cfg_index == rls_pkg::REG_WIDTH)
                            || (cfg_index == rls_pkg::REG_HEIGHT));

    always_comb
    begin
        push_entry.col   = col_sel;
        push_entry.first = (col_sel == '0);
        push_entry.eor   = last;
        push_entry.east_self = last;
        if (action == rls_pkg::ACT_DRAIN)
        begin
            push_entry.write_en   = 1'b0;
            push_entry.emit       = 1'b1;
            push_entry.drain      = 1'b1;
            push_entry.cbank      = ~eff_h[0];
            push_entry.north_self = (eff_h == rls_pkg::HEIGHT_W'(1));
            push_entry.eof        = last;
            push_entry.pix        = '0;
        end
        else
        begin
            push_entry.write_en   = 1'b1;
            push_entry.emit       = (in_row_reg != '0);
            push_entry.drain      = 1'b0;
            push_entry.cbank      = ~in_row_reg[0];
            push_entry.north_self = (in_row_reg[rls_pkg::HEIGHT_W-1:1] == '0);
            push_entry.eof        = 1'b0;
            push_entry.pix        = {blue, green, red};
        end
    end

    always_comb
    begin
        in_column_next    = in_column_reg;
        in_row_next       = in_row_reg;
        drain_column_next = drain_column_reg;
        priority if (geom_write)
        begin
            in_column_next    = '0;
            in_row_next       = '0;
            drain_column_next = '0;
        end
        else if (pixel_take)
        begin
            if (last)
            begin
                in_column_next = '0;
                in_row_next    = in_row_reg + rls_pkg::HEIGHT_W'(1);
            end
            else
            begin
                in_column_next = in_column_reg + rls_pkg::COL_W'(1);
            end
        end
        else if (drain_take)
        begin
            if (last)
            begin
                drain_column_next = '0;
                in_row_next       = '0;
                in_column_next    = '0;
            end
            else
            begin
                drain_column_next = drain_column_reg + rls_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= rls_pkg::WIDTH_RESET;
            image_height_reg <= rls_pkg::HEIGHT_RESET;
            in_column_reg    <= '0;
            in_row_reg       <= '0;
            drain_column_reg <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == rls_pkg::REG_WIDTH))
            begin
                image_width_reg <= cfg_data[rls_pkg::WIDTH_FIELD_W-1:0];
            end
            if (cfg_write && (cfg_index == rls_pkg::REG_HEIGHT))
            begin
                image_height_reg <= cfg_data[rls_pkg::HEIGHT_W-1:0];
            end
            in_column_reg    <= in_column_next;
            in_row_reg       <= in_row_next;
            drain_column_reg <= drain_column_next;
        end
    end

endmodule

// ===== sv/rls_queue.sv =====
// ---------------------------------------------------------------------------
// rls_queue: work queue between front and back
// Small FIFO of classified entries; full holds off the input channel.
// ---------------------------------------------------------------------------
module rls_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rls_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output rls_pkg::entry_t q_entry
);

    rls_pkg::entry_t              slot_reg [rls_pkg::QDEPTH];
    logic [rls_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rls_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rls_pkg::QPTR_W:0]     count_reg, count_next;

    assign full    = (count_reg == (rls_pkg::QPTR_W + 1)'(rls_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (rls_pkg::QPTR_W + 1)'(1);
            2'b01:   count_next = count_reg - (rls_pkg::QPTR_W + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rls_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rls_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/rls_back.sv =====
// ---------------------------------------------------------------------------
// rls_back: execution side of the sharpen unit
// Line stores, 3x3 cross window, per-channel Laplacian, gain multiply,
// clamp and output register. All stages advance together.
// ---------------------------------------------------------------------------
module rls_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             q_valid,
    input  rls_pkg::entry_t                  q_entry,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rls_pkg::CH_W-1:0]         out_red,
    output logic [rls_pkg::CH_W-1:0]         out_green,
    output logic [rls_pkg::CH_W-1:0]         out_blue,
    output logic                             end_of_row,
    output logic                             end_of_frame
);

    localparam int PROD_W = rls_pkg::STRENGTH_W + rls_pkg::LAP_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(65535);

    logic signed [rls_pkg::STRENGTH_W-1:0] strength_reg;

    logic [rls_pkg::PIX_W-1:0] bank0_mem [rls_pkg::MAX_WIDTH];
    logic [rls_pkg::PIX_W-1:0] bank1_mem [rls_pkg::MAX_WIDTH];
    logic [rls_pkg::PIX_W-1:0] head_reg  [2];
    logic [rls_pkg::PIX_W-1:0] rd0_reg;
    logic [rls_pkg::PIX_W-1:0] rd1_reg;

    logic                      advance;
    logic [rls_pkg::COL_W-1:0] col_inc;
    logic [rls_pkg::COL_W-1:0] addr0;
    logic [rls_pkg::COL_W-1:0] addr1;
    logic                      wr0;
    logic                      wr1;

    logic                      s2_valid_reg;
    rls_pkg::entry_t           s2_entry_reg;
    logic [rls_pkg::PIX_W-1:0] s2_head_reg;
    logic [rls_pkg::PIX_W-1:0] win_c_reg;
    logic [rls_pkg::PIX_W-1:0] win_e_reg;

    logic [rls_pkg::PIX_W-1:0] rd_c;
    logic [rls_pkg::PIX_W-1:0] rd_n;
    logic [rls_pkg::PIX_W-1:0] cen;
    logic [rls_pkg::PIX_W-1:0] wst;
    logic [rls_pkg::PIX_W-1:0] est;
    logic [rls_pkg::PIX_W-1:0] nth;
    logic [rls_pkg::PIX_W-1:0] sth;
    logic signed [rls_pkg::LAP_W-1:0] lap_c [3];

    logic                             s3_valid_reg;
    logic signed [rls_pkg::LAP_W-1:0] s3_lap_reg [3];
    logic [rls_pkg::PIX_W-1:0]        s3_cen_reg;
    logic                             s3_eor_reg;
    logic                             s3_eof_reg;

    logic signed [PROD_W-1:0]  prod [3];
    logic signed [SUM_W-1:0]   sum  [3];
    logic [rls_pkg::PIX_W-1:0] res;

    logic                      out_valid_reg;
    logic [rls_pkg::PIX_W-1:0] out_pix_reg;
    logic                      out_eor_reg;
    logic                      out_eof_reg;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && q_valid;

    // stage 1: line store access
    assign col_inc = q_entry.col + rls_pkg::COL_W'(1);
    assign addr0   = q_entry.cbank ? q_entry.col : col_inc;
    assign addr1   = q_entry.cbank ? col_inc : q_entry.col;
    assign wr0     = pop && q_entry.write_en && q_entry.cbank;
    assign wr1     = pop && q_entry.write_en && !q_entry.cbank;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd0_reg <= bank0_mem[addr0];
        end
        if (wr0)
        begin
            bank0_mem[q_entry.col] <= q_entry.pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd1_reg <= bank1_mem[addr1];
        end
        if (wr1)
        begin
            bank1_mem[q_entry.col] <= q_entry.pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_entry.write_en && q_entry.first)
        begin
            head_reg[~q_entry.cbank] <= q_entry.pix;
        end
        if (advance)
        begin
            s2_entry_reg <= q_entry;
            s2_head_reg  <= head_reg[q_entry.cbank];
        end
    end

    // stage 2: window and Laplacian
    assign rd_c = s2_entry_reg.cbank ? rd1_reg : rd0_reg;
    assign rd_n = s2_entry_reg.cbank ? rd0_reg : rd1_reg;
    assign cen  = s2_entry_reg.first ? s2_head_reg : win_e_reg;
    assign wst  = s2_entry_reg.first ? s2_head_reg : win_c_reg;
    assign est  = s2_entry_reg.east_self ? cen : rd_c;
    assign nth  = s2_entry_reg.north_self ? cen : rd_n;
    assign sth  = s2_entry_reg.drain ? cen : s2_entry_reg.pix;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            lap_c[ch] = $signed({1'b0, cen[ch*rls_pkg::CH_W +: rls_pkg::CH_W], 2'b00})
                      - $signed({3'b000, nth[ch*rls_pkg::CH_W +: rls_pkg::CH_W]})
                      - $signed({3'b000, sth[ch*rls_pkg::CH_W +: rls_pkg::CH_W]})
                      - $signed({3'b000, est[ch*rls_pkg::CH_W +: rls_pkg::CH_W]})
                      - $signed({3'b000, wst[ch*rls_pkg::CH_W +: rls_pkg::CH_W]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            win_c_reg <= cen;
            win_e_reg <= est;
        end
        if (advance)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s3_lap_reg[ch] <= lap_c[ch];
            end
            s3_cen_reg <= cen;
            s3_eor_reg <= s2_entry_reg.eor;
            s3_eof_reg <= s2_entry_reg.eof;
        end
    end

    // stage 3: gain, clamp
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = PROD_W'(strength_reg) * PROD_W'(s3_lap_reg[ch]);
            sum[ch]  = SUM_W'(prod[ch])
                     + SUM_W'($signed({1'b0, s3_cen_reg[ch*rls_pkg::CH_W +: rls_pkg::CH_W],
                                       8'h00}));
            if (sum[ch] < 0)
            begin
                res[ch*rls_pkg::CH_W +: rls_pkg::CH_W] = '0;
            end
            else if (sum[ch] > SUM_MAX)
            begin
                res[ch*rls_pkg::CH_W +: rls_pkg::CH_W] = '1;
            end
            else
            begin
                res[ch*rls_pkg::CH_W +: rls_pkg::CH_W] = sum[ch][15:8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pix_reg <= res;
            out_eor_reg <= s3_eor_reg;
            out_eof_reg <= s3_eof_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg  <= rls_pkg::STRENGTH_RESET;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == rls_pkg::REG_STRENGTH))
            begin
                strength_reg <= $signed(cfg_data[rls_pkg::STRENGTH_W-1:0]);
            end
            if (advance)
            begin
                s2_valid_reg  <= q_valid && q_entry.emit;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_red      = out_pix_reg[0 +: rls_pkg::CH_W];
    assign out_green    = out_pix_reg[rls_pkg::CH_W +: rls_pkg::CH_W];
    assign out_blue     = out_pix_reg[2*rls_pkg::CH_W +: rls_pkg::CH_W];
    assign end_of_row   = out_eor_reg;
    assign end_of_frame = out_eof_reg;

endmodule

// ===== sv/rls_checker.sv =====
// ---------------------------------------------------------------------------
// rls_checker: port-level checks for the sharpen unit
// Output hold under stall, frame/row flag consistency and queue backpressure.
// ---------------------------------------------------------------------------
module rls_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [rls_pkg::CH_W-1:0] out_red,
    input logic [rls_pkg::CH_W-1:0] out_green,
    input logic [rls_pkg::CH_W-1:0] out_blue,
    input logic                     end_of_row,
    input logic                     end_of_frame
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({out_red, out_green, out_blue, end_of_row, end_of_frame}))
        else $error("stalled output transaction changed");

    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> end_of_row)
        else $error("end_of_frame without end_of_row");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("queue full while output side is empty");

endmodule

bind rgb_laplacian_sharpen_unit rls_checker u_rls_checker (.*);

// ===== test/rgb_laplacian_sharpen_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_laplacian_sharpen_unit_test: self-checking bench for the sharpen unit
// Drives raster frames, drain ticks and register writes with random gaps on
// both channels. A scoreboard keeps its own line stores and counters and
// predicts every sharpened pixel with its row and frame marks. Each pixel
// that leaves the unit is compared in order against the oldest prediction.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic [rls_pkg::CH_W-1:0] red;
    logic [rls_pkg::CH_W-1:0] green;
    logic [rls_pkg::CH_W-1:0] blue;
    logic                     eor;
    logic                     eof;
} sharp_pixel_t;

class sharpen_scoreboard;
    logic signed [rls_pkg::STRENGTH_W-1:0] strength;
    logic [rls_pkg::WIDTH_FIELD_W-1:0]     width_field;
    logic [rls_pkg::HEIGHT_W-1:0]          height_field;
    logic [rls_pkg::PIX_W-1:0]             line_store [2][rls_pkg::MAX_WIDTH];
    int                                    in_col;
    int                                    in_row;
    int                                    drain_col;
    sharp_pixel_t                          awaited_pixels [$];
    int                                    errors;

    function new();
        strength     = rls_pkg::STRENGTH_RESET;
        width_field  = rls_pkg::WIDTH_RESET;
        height_field = rls_pkg::HEIGHT_RESET;
        in_col       = 0;
        in_row       = 0;
        drain_col    = 0;
        errors       = 0;
    endfunction

    function int eff_width();
        if (width_field == 0)
            return 1;
        if (width_field > rls_pkg::MAX_WIDTH)
            return rls_pkg::MAX_WIDTH;
        return int'(width_field);
    endfunction

    function int eff_height();
        return (height_field == 0) ? 1 : int'(height_field);
    endfunction

    function void configure(input logic [rls_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [rls_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rls_pkg::REG_STRENGTH:
                strength = data[rls_pkg::STRENGTH_W-1:0];
            rls_pkg::REG_WIDTH:
            begin
                width_field = data[rls_pkg::WIDTH_FIELD_W-1:0];
                in_col      = 0;
                in_row      = 0;
                drain_col   = 0;
            end
            rls_pkg::REG_HEIGHT:
            begin
                height_field = data[rls_pkg::HEIGHT_W-1:0];
                in_col       = 0;
                in_row       = 0;
                drain_col    = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function logic [7:0] sharpen_channel(input logic [7:0] c, n, s, e, w);
        int lap;
        int acc;
        lap = 4 * int'(c) - int'(n) - int'(s) - int'(e) - int'(w);
        acc = 256 * int'(c) + int'(strength) * lap;
        if (acc < 0)
            acc = 0;
        if (acc > 65535)
            acc = 65535;
        return acc[15:8];
    endfunction

    function void queue_pixel(input logic [23:0] c, n, s, e, w, input logic eor, eof);
        sharp_pixel_t p;
        p.red   = sharpen_channel(c[7:0], n[7:0], s[7:0], e[7:0], w[7:0]);
        p.green = sharpen_channel(c[15:8], n[15:8], s[15:8], e[15:8], w[15:8]);
        p.blue  = sharpen_channel(c[23:16], n[23:16], s[23:16], e[23:16], w[23:16]);
        p.eor   = eor;
        p.eof   = eof;
        awaited_pixels.push_back(p);
    endfunction

    function void note_input(input logic act, input logic [7:0] r, g, b);
        int          wd;
        int          ht;
        int          cur;
        int          upper;
        int          col;
        int          east_col;
        int          west_col;
        logic [23:0] pix;
        logic [23:0] c;
        logic [23:0] north;
        logic        row_done;
        wd = eff_width();
        ht = eff_height();
        if (act == rls_pkg::ACT_PIXEL)
        begin
            if (in_row >= ht || in_col >= wd)
                return;
            col = in_col;
            pix = {b, g, r};
            cur = in_row % 2;
            if (in_row >= 1)
            begin
                upper    = 1 - cur;
                east_col = (col + 1 < wd) ? col + 1 : col;
                west_col = (col > 0) ? col - 1 : 0;
                c        = line_store[upper][col];
                north    = (in_row >= 2) ? line_store[cur][col] : c;
                queue_pixel(c, north, pix, line_store[upper][east_col],
                            line_store[upper][west_col], col + 1 == wd, 1'b0);
            end
            line_store[cur][col] = pix;
            if (col + 1 >= wd)
            begin
                in_col = 0;
                in_row = in_row + 1;
            end
            else
                in_col = col + 1;
        end
        else
        begin
            if (in_row < ht || drain_col >= wd)
                return;
            col      = drain_col;
            cur      = (ht - 1) % 2;
            east_col = (col + 1 < wd) ? col + 1 : col;
            west_col = (col > 0) ? col - 1 : 0;
            c        = line_store[cur][col];
            north    = (ht >= 2) ? line_store[1 - cur][col] : c;
            row_done = (col + 1 == wd);
            queue_pixel(c, north, c, line_store[cur][east_col], line_store[cur][west_col],
                        row_done, row_done);
            if (row_done)
            begin
                drain_col = 0;
                in_row    = 0;
                in_col    = 0;
            end
            else
                drain_col = col + 1;
        end
    endfunction

    function string describe(input sharp_pixel_t p);
        return $sformatf("r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                         p.red, p.green, p.blue, p.eor, p.eof);
    endfunction

    function void flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(input logic [7:0] r, g, b, input logic eor, eof);
        sharp_pixel_t got;
        sharp_pixel_t want;
        got.red   = r;
        got.green = g;
        got.blue  = b;
        got.eor   = eor;
        got.eof   = eof;
        if (awaited_pixels.size() == 0)
        begin
            flag({"pixel with none awaited: ", describe(got)});
            return;
        end
        want = awaited_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
            || got.eor !== want.eor || got.eof !== want.eof)
            flag({"expected ", describe(want), ", got ", describe(got)});
    endfunction
endclass

module rgb_laplacian_sharpen_unit_test;

    localparam logic [rls_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 260;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 50000;

    logic                            clk;
    logic                            rst_n      = 1'b0;
    logic                            cfg_write  = 1'b0;
    logic [rls_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [rls_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic                            action     = rls_pkg::ACT_PIXEL;
    logic [rls_pkg::CH_W-1:0]        red        = '0;
    logic [rls_pkg::CH_W-1:0]        green      = '0;
    logic [rls_pkg::CH_W-1:0]        blue       = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic [rls_pkg::CH_W-1:0]        out_red;
    logic [rls_pkg::CH_W-1:0]        out_green;
    logic [rls_pkg::CH_W-1:0]        out_blue;
    logic                            end_of_row;
    logic                            end_of_frame;

    sharpen_scoreboard sb;
    bit                steady      = 1'b0;
    int                sent_items  = 0;
    int                cycle_count = 0;

    rgb_laplacian_sharpen_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!steady && $urandom_range(99) < 25)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(action, red, green, blue);
            if (out_valid && !out_stall)
                sb.check_result(out_red, out_green, out_blue, end_of_row, end_of_frame);
        end
    end

    function automatic logic [7:0] rand_channel();
        int pick;
        pick = $urandom_range(19);
        if (pick < 3)
            return 8'h00;
        if (pick < 6)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [11:0] random_strength();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1:    return 12'h800;
            2:       return 12'h7FF;
            3:       return 12'h000;
            4, 5:    return 12'h100;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic int effective_size(input int v, input int cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : v;
    endfunction

    task automatic send_item(input logic act, input logic [7:0] r, g, b);
        while (!steady && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (in_stall);
        sent_items++;
    endtask

    // drop valid and let every awaited pixel and in-flight transaction drain
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.awaited_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rls_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rls_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.configure(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_strength(input logic [11:0] s);
        logic [rls_pkg::CFG_DATA_W-1:0] d;
        d       = rls_pkg::CFG_DATA_W'($urandom);
        d[11:0] = s;
        write_reg(rls_pkg::REG_STRENGTH, d);
    endtask

    task automatic set_geometry(input int wv, input int hv);
        logic [rls_pkg::CFG_DATA_W-1:0] d;
        bit                             width_first;
        d           = rls_pkg::CFG_DATA_W'($urandom);
        d[10:0]     = wv[10:0];
        width_first = $urandom_range(1);
        if (width_first)
            write_reg(rls_pkg::REG_WIDTH, d);
        write_reg(rls_pkg::REG_HEIGHT, hv[15:0]);
        if (!width_first)
            write_reg(rls_pkg::REG_WIDTH, d);
    endtask

    task automatic run_frame(input int wd, input int ht, input bit noisy, input bit retune);
        int n;
        n = wd * ht;
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(99) < 8)
                send_item(rls_pkg::ACT_DRAIN, rand_channel(), rand_channel(),
                          rand_channel());
            if (retune && i == n / 2)
            begin
                settle();
                set_strength(random_strength());
            end
            send_item(rls_pkg::ACT_PIXEL, rand_channel(), rand_channel(), rand_channel());
        end
        if (noisy && $urandom_range(1))
            send_item(rls_pkg::ACT_PIXEL, rand_channel(), rand_channel(), rand_channel());
        for (int i = 0; i < wd; i++)
            send_item(rls_pkg::ACT_DRAIN, rand_channel(), rand_channel(), rand_channel());
    endtask

    initial
    begin
        int wv;
        int hv;
        int wd;
        int ht;
        int count;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: first row emits nothing, early drain is dropped
        send_item(rls_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(rls_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(rls_pkg::ACT_PIXEL, 8'h55, 8'hAA, 8'h0F);
        send_item(rls_pkg::ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        settle();
        write_reg(rls_pkg::REG_WIDTH, 16'd3);
        write_reg(rls_pkg::REG_HEIGHT, 16'd2);
        send_item(rls_pkg::ACT_PIXEL, 8'hFF, 8'h00, 8'hFF);
        send_item(rls_pkg::ACT_PIXEL, 8'h00, 8'hFF, 8'h00);
        send_item(rls_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(rls_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(rls_pkg::ACT_PIXEL, 8'hFF, 8'h80, 8'h01);
        send_item(rls_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'hFF);
        send_item(rls_pkg::ACT_PIXEL, 8'h12, 8'h34, 8'h56);
        send_item(rls_pkg::ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(rls_pkg::ACT_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        send_item(rls_pkg::ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(rls_pkg::ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        settle();
        write_reg(rls_pkg::REG_STRENGTH, 16'hF800);
        write_reg(rls_pkg::REG_WIDTH, 16'd1);
        write_reg(rls_pkg::REG_HEIGHT, 16'd1);
        send_item(rls_pkg::ACT_PIXEL, 8'hC8, 8'h03, 8'hFF);
        send_item(rls_pkg::ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        settle();
        write_reg(rls_pkg::REG_STRENGTH, 16'h07FF);
        write_reg(rls_pkg::REG_WIDTH, 16'hF800);
        write_reg(rls_pkg::REG_HEIGHT, 16'h0000);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_item(rls_pkg::ACT_PIXEL, 8'h01, 8'hFE, 8'h80);
        send_item(rls_pkg::ACT_DRAIN, 8'hFF, 8'hFF, 8'hFF);

        while (sent_items < RANDOM_ITEMS)
        begin
            settle();
            set_strength(random_strength());
            case ($urandom_range(9))
                0:       wv = 0;
                1:       wv = 1;
                2:       wv = $urandom_range(20, 9);
                default: wv = $urandom_range(8, 2);
            endcase
            hv = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
            set_geometry(wv, hv);
            if ($urandom_range(9) == 0)
                write_reg(REG_UNUSED, rls_pkg::CFG_DATA_W'($urandom));
            wd = effective_size(wv, rls_pkg::MAX_WIDTH);
            ht = effective_size(hv, 65535);
            if ($urandom_range(9) < 8)
                run_frame(wd, ht, $urandom_range(3) == 0, $urandom_range(3) == 0);
            else
            begin
                count = $urandom_range(2 * wd * ht + 1, 1);
                for (int i = 0; i < count; i++)
                    send_item(logic'($urandom_range(1)), rand_channel(), rand_channel(),
                              rand_channel());
            end
        end

        // tall single-column frame, abandoned by the next geometry write
        settle();
        set_geometry(1, 65535);
        for (int i = 0; i < 40; i++)
            send_item(rls_pkg::ACT_PIXEL, rand_channel(), rand_channel(), rand_channel());

        // full frame with no idling on either side
        settle();
        set_strength(random_strength());
        set_geometry(16, 4);
        steady = 1'b1;
        run_frame(16, 4, 1'b0, 1'b0);
        settle();
        steady = 1'b0;

        settle();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/rls_pkg.sv
sv/rls_front.sv
sv/rls_queue.sv
sv/rls_back.sv
sv/rgb_laplacian_sharpen_unit.sv
sv/rls_checker.sv
test/rgb_laplacian_sharpen_unit_test.sv
